// File: src/scrw_pkg.sv
// ----------------------------------------------------------------------------
// scrw_pkg
// Shared types and constants for the serial codec register writer.
// ----------------------------------------------------------------------------
package scrw_pkg;

    localparam int GPIO_WIDTH  = 24;
    localparam int FRAME_BITS  = 16;
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS);
    localparam int CFG_IDX_W   = 3;
    localparam int ADDR_SENT_W = 5;

    localparam logic [BIT_IDX_W-1:0] BIT_FIRST = BIT_IDX_W'(FRAME_BITS - 1);
    localparam logic [BIT_IDX_W-1:0] BIT_LAST  = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_BITS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_BITS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_PATTERN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PATTERN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_SET_BITS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_CLEAR_BITS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CS_STYLE         = 3'd7;

    localparam int CS_START_HIGH = 0;
    localparam int CS_NEW_SCHEME = 1;

    typedef logic [GPIO_WIDTH-1:0] word_t;

    // masks the sequencer needs while words go out
    typedef struct packed {
        word_t clock_bits;
        word_t data_bits;
        word_t select_bits;
        word_t idle_pattern;
    } seq_cfg_t;

    // one classified request, as queued between front and back
    typedef struct packed {
        word_t                 start_word;
        logic [FRAME_BITS-1:0] frame;
        logic                  emit_first;
        logic                  separate;
        logic                  desel;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FIRST,
        BK_BITS,
        BK_DESEL,
        BK_LAST
    } back_state_t;

    typedef enum logic [1:0] {
        PH_FALL,
        PH_DATA,
        PH_RISE
    } phase_t;

endpackage

// File: src/scrw_front.sv
// ----------------------------------------------------------------------------
// scrw_front
// Configuration registers and request classification: forms the frame and
// the starting word and picks the chip select framing.
// ----------------------------------------------------------------------------
module scrw_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [scrw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scrw_pkg::GPIO_WIDTH-1:0]      cfg_data,
    input  logic [scrw_pkg::GPIO_WIDTH-1:0]      gpio_now,
    input  logic [1:0]                           chip_code,
    input  logic [7:0]                           reg_addr,
    input  logic [7:0]                           reg_data,
    output scrw_pkg::cmd_t                       cmd,
    output scrw_pkg::seq_cfg_t                   seq_cfg
);

    scrw_pkg::word_t clock_bits_reg,       clock_bits_next;
    scrw_pkg::word_t data_bits_reg,        data_bits_next;
    scrw_pkg::word_t select_bits_reg,      select_bits_next;
    scrw_pkg::word_t select_pattern_reg,   select_pattern_next;
    scrw_pkg::word_t idle_pattern_reg,     idle_pattern_next;
    scrw_pkg::word_t force_set_bits_reg,   force_set_bits_next;
    scrw_pkg::word_t force_clear_bits_reg, force_clear_bits_next;
    logic [1:0]      cs_style_reg,         cs_style_next;

    scrw_pkg::word_t base_word;
    logic            new_scheme;
    logic            start_high;
    logic            separate;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        clock_bits_next       = clock_bits_reg;
        data_bits_next        = data_bits_reg;
        select_bits_next      = select_bits_reg;
        select_pattern_next   = select_pattern_reg;
        idle_pattern_next     = idle_pattern_reg;
        force_set_bits_next   = force_set_bits_reg;
        force_clear_bits_next = force_clear_bits_reg;
        cs_style_next         = cs_style_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                scrw_pkg::REG_CLOCK_BITS:       clock_bits_next       = cfg_data;
                scrw_pkg::REG_DATA_BITS:        data_bits_next        = cfg_data;
                scrw_pkg::REG_SELECT_BITS:      select_bits_next      = cfg_data;
                scrw_pkg::REG_SELECT_PATTERN:   select_pattern_next   = cfg_data;
                scrw_pkg::REG_IDLE_PATTERN:     idle_pattern_next     = cfg_data;
                scrw_pkg::REG_FORCE_SET_BITS:   force_set_bits_next   = cfg_data;
                scrw_pkg::REG_FORCE_CLEAR_BITS: force_clear_bits_next = cfg_data;
                scrw_pkg::REG_CS_STYLE:         cs_style_next         = cfg_data[1:0];
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_bits_reg       <= '0;
            data_bits_reg        <= '0;
            select_bits_reg      <= '0;
            select_pattern_reg   <= '0;
            idle_pattern_reg     <= '0;
            force_set_bits_reg   <= '0;
            force_clear_bits_reg <= '0;
            cs_style_reg         <= '0;
        end
        else
        begin
            clock_bits_reg       <= clock_bits_next;
            data_bits_reg        <= data_bits_next;
            select_bits_reg      <= select_bits_next;
            select_pattern_reg   <= select_pattern_next;
            idle_pattern_reg     <= idle_pattern_next;
            force_set_bits_reg   <= force_set_bits_next;
            force_clear_bits_reg <= force_clear_bits_next;
            cs_style_reg         <= cs_style_next;
        end
    end

    assign new_scheme = cs_style_reg[scrw_pkg::CS_NEW_SCHEME];
    assign start_high = cs_style_reg[scrw_pkg::CS_START_HIGH];
    assign separate   = new_scheme && (select_bits_reg != select_pattern_reg);

    always_comb
    begin
        base_word = gpio_now | force_set_bits_reg;
        if (new_scheme)
        begin
            base_word = base_word & ~force_clear_bits_reg;
        end

        cmd.frame      = {chip_code, 1'b1, reg_addr[scrw_pkg::ADDR_SENT_W-1:0], reg_data};
        cmd.separate   = separate;
        cmd.desel      = !separate && start_high;
        priority if (separate)
        begin
            cmd.start_word = (base_word & ~select_bits_reg) | select_pattern_reg;
            cmd.emit_first = 1'b1;
        end
        else if (start_high)
        begin
            // select raised silently; no word for it
            cmd.start_word = base_word | select_bits_reg;
            cmd.emit_first = 1'b0;
        end
        else
        begin
            cmd.start_word = base_word & ~select_bits_reg;
            cmd.emit_first = 1'b1;
        end
    end

    assign seq_cfg.clock_bits   = clock_bits_reg;
    assign seq_cfg.data_bits    = data_bits_reg;
    assign seq_cfg.select_bits  = select_bits_reg;
    assign seq_cfg.idle_pattern = idle_pattern_reg;

endmodule

// File: src/scrw_cmd_queue.sv
// ----------------------------------------------------------------------------
// scrw_cmd_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module scrw_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  scrw_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output scrw_pkg::cmd_t rd_cmd,
    output logic           empty
);

    scrw_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg,  count_next;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: src/scrw_back.sv
// ----------------------------------------------------------------------------
// scrw_back
// Word sequencer: walks one request through its fifty GPIO words and holds
// the oldest word in an output register.
// ----------------------------------------------------------------------------
module scrw_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scrw_pkg::seq_cfg_t     seq_cfg,
    input  scrw_pkg::cmd_t         q_cmd,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   empty,
    input  logic                   pop,
    output scrw_pkg::word_t        gpio_word,
    output logic                   last_word
);

    scrw_pkg::back_state_t               state_reg, state_next;
    scrw_pkg::phase_t                    phase_reg, phase_next;
    logic [scrw_pkg::BIT_IDX_W-1:0]      bit_reg,   bit_next;
    scrw_pkg::word_t                     w_reg;
    logic [scrw_pkg::FRAME_BITS-1:0]     frame_reg;
    logic                                sep_reg;
    logic                                desel_reg;
    scrw_pkg::word_t                     out_word_reg;
    logic                                out_last_reg;
    logic                                out_valid_reg, out_valid_next;

    logic            adv;
    logic            load;
    logic            emit;
    logic            emit_last;
    scrw_pkg::word_t word;

    // output slot free, or its word is being taken this cycle
    assign adv = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        load       = 1'b0;
        unique case (state_reg)
            scrw_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    load = 1'b1;
                end
            end
            scrw_pkg::BK_FIRST:
            begin
                if (adv)
                begin
                    state_next = scrw_pkg::BK_BITS;
                end
            end
            scrw_pkg::BK_BITS:
            begin
                if (adv)
                begin
                    unique case (phase_reg)
                        scrw_pkg::PH_FALL: phase_next = scrw_pkg::PH_DATA;
                        scrw_pkg::PH_DATA: phase_next = scrw_pkg::PH_RISE;
                        default:
                        begin
                            phase_next = scrw_pkg::PH_FALL;
                            if (bit_reg == scrw_pkg::BIT_LAST)
                            begin
                                state_next = desel_reg ? scrw_pkg::BK_DESEL
                                                       : scrw_pkg::BK_LAST;
                            end
                            else
                            begin
                                bit_next = bit_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end
            scrw_pkg::BK_DESEL:
            begin
                if (adv)
                begin
                    state_next = scrw_pkg::BK_LAST;
                end
            end
            default:
            begin
                if (adv)
                begin
                    // pick up the next request without a gap
                    if (!q_empty)
                    begin
                        load = 1'b1;
                    end
                    else
                    begin
                        state_next = scrw_pkg::BK_IDLE;
                    end
                end
            end
        endcase
        if (load)
        begin
            state_next = q_cmd.emit_first ? scrw_pkg::BK_FIRST : scrw_pkg::BK_BITS;
            phase_next = scrw_pkg::PH_FALL;
            bit_next   = scrw_pkg::BIT_FIRST;
        end
    end

    always_comb
    begin
        word      = w_reg;
        emit      = 1'b0;
        emit_last = 1'b0;
        unique case (state_reg)
            scrw_pkg::BK_IDLE:
            begin
                word = w_reg;
            end
            scrw_pkg::BK_FIRST:
            begin
                emit = adv;
            end
            scrw_pkg::BK_BITS:
            begin
                emit = adv;
                unique case (phase_reg)
                    scrw_pkg::PH_FALL: word = w_reg & ~seq_cfg.clock_bits;
                    scrw_pkg::PH_DATA:
                    begin
                        word = frame_reg[bit_reg] ? (w_reg | seq_cfg.data_bits)
                                                  : (w_reg & ~seq_cfg.data_bits);
                    end
                    default:           word = w_reg | seq_cfg.clock_bits;
                endcase
            end
            scrw_pkg::BK_DESEL:
            begin
                emit = adv;
                word = w_reg & ~seq_cfg.select_bits;
            end
            default:
            begin
                emit      = adv;
                emit_last = 1'b1;
                word      = sep_reg ? ((w_reg & ~seq_cfg.select_bits) | seq_cfg.idle_pattern)
                                    : (w_reg | seq_cfg.select_bits);
            end
        endcase
    end

    assign q_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scrw_pkg::BK_IDLE;
            phase_reg     <= scrw_pkg::PH_FALL;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg     <= q_cmd.start_word;
            frame_reg <= q_cmd.frame;
            sep_reg   <= q_cmd.separate;
            desel_reg <= q_cmd.desel;
        end
        else if (emit)
        begin
            w_reg <= word;
        end
        if (emit)
        begin
            out_word_reg <= word;
            out_last_reg <= emit_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign gpio_word = out_word_reg;
    assign last_word = out_last_reg;

endmodule

// File: src/serial_codec_register_writer.sv
// ----------------------------------------------------------------------------
// serial_codec_register_writer
// Turns codec register write requests into the GPIO word sequence that
// bit-bangs a 16-bit write frame over a three-wire serial port.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full: gpio_now, chip_code, reg_addr and
//   reg_data are taken when push is high and full is low. Two classified
//   requests can wait in the internal queue besides the one being sent.
//   Results leave through empty/pop: gpio_word and last_word show the oldest
//   word while empty is low; pop takes it. Every request gives exactly 50
//   words, the last one with last_word set.
//   A request passes through the queue and the sequencer registers into the
//   output register. The word sequencer produces one word per cycle while no
//   word waits unpopped; back-to-back requests leave as an unbroken stream.
//   If pop is held low the output register holds its word and the sequencer
//   waits; requests still queue until full rises.
//   Configuration registers are written through cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high. Write them only while
//   no request is in flight.
//   Reset clears all configuration registers, empties the queue and the
//   output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_codec_register_writer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [scrw_pkg::GPIO_WIDTH-1:0]  gpio_now,
    input  logic [1:0]                       chip_code,
    input  logic [7:0]                       reg_addr,
    input  logic [7:0]                       reg_data,
    output logic                             empty,
    input  logic                             pop,
    output logic [scrw_pkg::GPIO_WIDTH-1:0]  gpio_word,
    output logic                             last_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scrw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scrw_pkg::GPIO_WIDTH-1:0]  cfg_data
);

    scrw_pkg::cmd_t     front_cmd;
    scrw_pkg::cmd_t     q_cmd;
    scrw_pkg::seq_cfg_t seq_cfg;
    logic               q_wr;
    logic               q_rd;
    logic               q_empty;

    assign q_wr = push && !full;

    scrw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gpio_now  (gpio_now),
        .chip_code (chip_code),
        .reg_addr  (reg_addr),
        .reg_data  (reg_data),
        .cmd       (front_cmd),
        .seq_cfg   (seq_cfg)
    );

    scrw_cmd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (q_rd),
        .rd_cmd (q_cmd),
        .empty  (q_empty)
    );

    scrw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seq_cfg   (seq_cfg),
        .q_cmd     (q_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_rd),
        .empty     (empty),
        .pop       (pop),
        .gpio_word (gpio_word),
        .last_word (last_word)
    );

endmodule

// File: src/scrw_checker.sv
// ----------------------------------------------------------------------------
// scrw_checker
// Port-level checks on the register writer, bound to the top level.
// ----------------------------------------------------------------------------
module scrw_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             empty,
    input logic                             pop,
    input logic [scrw_pkg::GPIO_WIDTH-1:0]  gpio_word,
    input logic                             last_word,
    input logic                             cfg_ready
);

    localparam logic [5:0] WORDS_PER_WRITE = 6'd50;

    logic [5:0] out_cnt_reg, out_cnt_next;
    logic       out_xfer;

    assign out_xfer = pop && !empty;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (out_xfer)
        begin
            out_cnt_next = last_word ? '0 : out_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    // last word marked on the fiftieth transfer of a write, and only there
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (last_word == (out_cnt_reg == WORDS_PER_WRITE - 1'b1)))
        else $error("last_word out of place");

    // no write runs past fifty words
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg < WORDS_PER_WRITE)
        else $error("write longer than fifty words");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(gpio_word) && $stable(last_word)))
        else $error("waiting word changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind serial_codec_register_writer scrw_checker u_scrw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .gpio_word (gpio_word),
    .last_word (last_word),
    .cfg_ready (cfg_ready)
);
